// ----- sv/iecr_pkg.sv -----
// Shared types, status codes and checksum helper for the ICMP echo reply checker.
package iecr_pkg;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT_IP  = 3'd1;
  localparam logic [2:0] STATUS_SHORT_IHL = 3'd2;
  localparam logic [2:0] STATUS_SHORT_ICMP = 3'd3;
  localparam logic [2:0] STATUS_NOT_REPLY = 3'd4;
  localparam logic [2:0] STATUS_BAD_CSUM  = 3'd5;
  localparam logic [2:0] STATUS_WRONG_SIZE = 3'd6;

  localparam int IpMinHdr = 20;
  localparam int IcmpHdr = 8;
  localparam logic [11:0] EXPECTED_LEN_RESET = 12'd56;

  typedef struct packed {
    logic        short_ip;
    logic        short_ihl;
    logic        short_icmp;
    logic        plen_over;
    logic        odd;
    logic [12:0] plen;
    logic [7:0]  kind;
    logic [15:0] carried;
    logic [16:0] sum;
    logic [7:0]  pending;
    logic [15:0] ident;
    logic [15:0] seq;
  } rec_t;

  function automatic logic [16:0] add_word(input logic [16:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = s + {1'b0, w};
    return {1'b0, t[15:0]} + {16'd0, t[16]};
  endfunction

endpackage

// ----- sv/iecr_front.sv -----
// Byte intake: counts, captures ICMP header fields, accumulates the checksum and classifies.
module iecr_front import iecr_pkg::*; #(
  parameter int MAX_PACKET = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       rec_push,
  output rec_t       rec
);

  localparam int CW = $clog2(MAX_PACKET + 1);

  logic [CW-1:0] byte_count, byte_count_next;
  logic [5:0]    header_len, header_len_next;
  logic [7:0]    icmp_kind, icmp_kind_next;
  logic [15:0]   carried_checksum, carried_checksum_next;
  logic [16:0]   running_sum, running_sum_next;
  logic [7:0]    pending_high_byte, pending_high_byte_next;
  logic [15:0]   ident_reg, ident_reg_next;
  logic [15:0]   sequence_reg, sequence_reg_next;

  logic          counted;
  logic [CW-1:0] hl_ext;
  logic [CW-1:0] idx;
  logic [7:0]    v;
  logic [CW-1:0] ilen;
  logic [CW-1:0] plen_full;

  always_comb begin
    byte_count_next = byte_count;
    header_len_next = header_len;
    icmp_kind_next = icmp_kind;
    carried_checksum_next = carried_checksum;
    running_sum_next = running_sum;
    pending_high_byte_next = pending_high_byte;
    ident_reg_next = ident_reg;
    sequence_reg_next = sequence_reg;
    counted = byte_count < CW'(MAX_PACKET);
    if (counted && (byte_count == '0)) begin
      header_len_next = {data_byte[3:0], 2'b00};
    end
    hl_ext = CW'(header_len_next);
    idx = byte_count - hl_ext;
    v = data_byte;
    if (counted && (byte_count >= hl_ext)) begin
      if (idx == CW'(0)) icmp_kind_next = data_byte;
      if (idx == CW'(2)) begin
        carried_checksum_next[15:8] = data_byte;
        v = 8'd0;
      end
      if (idx == CW'(3)) begin
        carried_checksum_next[7:0] = data_byte;
        v = 8'd0;
      end
      if (idx == CW'(4)) ident_reg_next[15:8] = data_byte;
      if (idx == CW'(5)) ident_reg_next[7:0] = data_byte;
      if (idx == CW'(6)) sequence_reg_next[15:8] = data_byte;
      if (idx == CW'(7)) sequence_reg_next[7:0] = data_byte;
      if (!idx[0]) begin
        pending_high_byte_next = v;
      end else begin
        running_sum_next = add_word(running_sum, {pending_high_byte, v});
      end
    end
    if (counted) begin
      byte_count_next = byte_count + CW'(1);
    end
    ilen = byte_count_next - hl_ext;
    plen_full = ilen - CW'(IcmpHdr);
  end

  always_comb begin
    rec_push = take && last;
    rec.short_ip = byte_count_next < CW'(IpMinHdr);
    rec.short_ihl = byte_count_next < hl_ext;
    rec.short_icmp = ilen < CW'(IcmpHdr);
    rec.plen_over = (plen_full >> 12) != '0;
    rec.odd = ilen[0];
    rec.plen = 13'(plen_full);
    rec.kind = icmp_kind_next;
    rec.carried = carried_checksum_next;
    rec.sum = running_sum_next;
    rec.pending = pending_high_byte_next;
    rec.ident = ident_reg_next;
    rec.seq = sequence_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      byte_count <= '0;
      header_len <= '0;
      icmp_kind <= '0;
      carried_checksum <= '0;
      running_sum <= '0;
      pending_high_byte <= '0;
      ident_reg <= '0;
      sequence_reg <= '0;
    end else if (take) begin
      byte_count <= byte_count_next;
      header_len <= header_len_next;
      icmp_kind <= icmp_kind_next;
      carried_checksum <= carried_checksum_next;
      running_sum <= running_sum_next;
      pending_high_byte <= pending_high_byte_next;
      ident_reg <= ident_reg_next;
      sequence_reg <= sequence_reg_next;
    end
  end

endmodule

// ----- sv/iecr_fifo.sv -----
// Two-entry queue of classified datagram records between intake and evaluation.
module iecr_fifo import iecr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  rec_t wr_rec,
  output logic full,
  input  logic rd,
  output rec_t rd_rec,
  output logic empty
);

  rec_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign rd_rec = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      case ({wr, rd})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/iecr_back.sv -----
// Evaluation: finishes the checksum, picks the status and holds the result register.
module iecr_back import iecr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [11:0] cfg_data,
  input  logic        rec_avail,
  input  rec_t        rec,
  output logic        rec_take,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  status,
  output logic [15:0] ident,
  output logic [15:0] sequence_res,
  output logic [12:0] payload_len
);

  logic [11:0] expected_payload_len;
  logic        out_valid;
  logic [16:0] s_pad;
  logic [16:0] s_fold;
  logic [15:0] calc;
  logic [2:0]  status_next;
  logic [15:0] ident_next;
  logic [15:0] sequence_next;
  logic [12:0] plen_next;

  assign empty = !out_valid;
  assign rec_take = rec_avail && (!out_valid || pop);

  always_comb begin
    s_pad = rec.odd ? add_word(rec.sum, {rec.pending, 8'd0}) : rec.sum;
    s_fold = {1'b0, s_pad[15:0]} + {16'd0, s_pad[16]};
    calc = ~s_fold[15:0];
    ident_next = 16'd0;
    sequence_next = 16'd0;
    plen_next = 13'd0;
    if (rec.short_ip) begin
      status_next = STATUS_SHORT_IP;
    end else if (rec.short_ihl) begin
      status_next = STATUS_SHORT_IHL;
    end else if (rec.short_icmp) begin
      status_next = STATUS_SHORT_ICMP;
    end else begin
      plen_next = rec.plen;
      if (rec.kind != 8'd0) begin
        status_next = STATUS_NOT_REPLY;
      end else if (calc != rec.carried) begin
        status_next = STATUS_BAD_CSUM;
      end else begin
        ident_next = rec.ident;
        sequence_next = rec.seq;
        if (rec.plen_over || (rec.plen[11:0] != expected_payload_len)) begin
          status_next = STATUS_WRONG_SIZE;
        end else begin
          status_next = STATUS_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_payload_len <= EXPECTED_LEN_RESET;
    end else if (cfg_valid) begin
      expected_payload_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      status <= status_next;
      ident <= ident_next;
      sequence_res <= sequence_next;
      payload_len <= plen_next;
    end
  end

endmodule

// ----- sv/icmp_echo_reply_checker_core.sv -----
// Top level of the ICMP echo reply checker: intake, record queue and evaluation.
//
//   Channel  Handshake          Transfer when          Payload
//   bytes    push / full        push && !full          data_byte, last
//   results  empty / pop        pop && !empty          status, ident, sequence_res, payload_len
//   config   cfg_valid/ready    cfg_valid && cfg_ready cfg_data
//
// One byte is taken every cycle while full is low; the intake adds one 16-bit word per byte pair.
// A datagram's record goes into the record queue on its last byte, then into the result register.
// Reset clears all packet state and sets the expected payload length to 56.
// Full rises only when two results wait in the record queue behind a stalled output.
module icmp_echo_reply_checker_core import iecr_pkg::*; #(
  parameter int MAX_PACKET = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [15:0] ident,
  output logic [15:0] sequence_res,
  output logic [12:0] payload_len,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  logic take;
  logic rec_push;
  rec_t front_rec;
  rec_t head_rec;
  logic q_full;
  logic q_empty;
  logic rec_take;

  assign cfg_ready = 1'b1;
  assign full = q_full;
  assign take = push && !q_full;

  iecr_front #(
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .take(take),
    .data_byte(data_byte),
    .last(last),
    .rec_push(rec_push),
    .rec(front_rec)
  );

  iecr_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .wr(rec_push),
    .wr_rec(front_rec),
    .full(q_full),
    .rd(rec_take),
    .rd_rec(head_rec),
    .empty(q_empty)
  );

  iecr_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .rec_avail(!q_empty),
    .rec(head_rec),
    .rec_take(rec_take),
    .pop(pop),
    .empty(empty),
    .status(status),
    .ident(ident),
    .sequence_res(sequence_res),
    .payload_len(payload_len)
  );

endmodule

// ----- tb/sv/icmp_echo_reply_checker_core_tb.sv -----
// Self-checking testbench for the ICMP echo reply checker: datagram bytes in, one verdict out.
`timescale 1ns / 100ps

module icmp_echo_reply_checker_core_tb;
  import iecr_pkg::*;

  localparam int MaxPacket = 4096;
  localparam int QuietLimit = 5000;
  localparam int SettleCycles = 8;
  localparam int IdlePercent = 13;

  typedef struct packed {
    logic [7:0] value;
    logic       final_byte;
    logic       hold;
  } wire_byte_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] ident_val;
    logic [15:0] seq_val;
    logic [12:0] plen_val;
  } echo_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status;
  logic [15:0] ident;
  logic [15:0] sequence_res;
  logic [12:0] payload_len;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = 12'd0;

  wire_byte_t    tx_queue[$];
  echo_verdict_t expected_verdicts[$];
  logic [7:0]    frame_bytes[$];

  logic [11:0] want_plen;
  logic [12:0] seen_bytes;
  logic [5:0]  hdr_len;
  logic [7:0]  kind_field;
  logic [15:0] csum_field;
  logic [16:0] word_sum;
  logic [7:0]  hi_byte;
  logic [15:0] id_field;
  logic [15:0] seq_field;

  logic [11:0] gen_len = EXPECTED_LEN_RESET;
  bit byte_taken;
  bit draining;
  bit cur_hold;
  bit steady;
  int errors;
  int verdicts_seen;
  int bytes_sent;
  int quiet_cycles;
  int verdict_hits[0:6];

  icmp_echo_reply_checker_core i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .last(last),
    .empty(empty),
    .pop(pop),
    .status(status),
    .ident(ident),
    .sequence_res(sequence_res),
    .payload_len(payload_len),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [16:0] fold_add(input logic [16:0] acc, input logic [15:0] w);
    logic [17:0] t;
    t = acc + w;
    return {1'b0, t[15:0]} + {15'd0, t[17:16]};
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic clear_frame_state();
    seen_bytes = '0;
    hdr_len = '0;
    kind_field = '0;
    csum_field = '0;
    word_sum = '0;
    hi_byte = '0;
    id_field = '0;
    seq_field = '0;
  endtask

  task automatic track_byte(input logic [7:0] b, input logic fin);
    int idx;
    int n;
    int ilen;
    int plen_int;
    logic [7:0] v;
    logic [16:0] s;
    logic [15:0] calc;
    echo_verdict_t r;
    if (seen_bytes < MaxPacket) begin
      if (seen_bytes == 0) hdr_len = {b[3:0], 2'b00};
      if (seen_bytes >= hdr_len) begin
        idx = seen_bytes - hdr_len;
        v = b;
        case (idx)
          0: kind_field = b;
          2: begin
            csum_field[15:8] = b;
            v = 8'h00;
          end
          3: begin
            csum_field[7:0] = b;
            v = 8'h00;
          end
          4: id_field[15:8] = b;
          5: id_field[7:0] = b;
          6: seq_field[15:8] = b;
          7: seq_field[7:0] = b;
          default: ;
        endcase
        if (idx % 2 == 0) hi_byte = v;
        else word_sum = fold_add(word_sum, {hi_byte, v});
      end
      seen_bytes = seen_bytes + 1'b1;
    end
    if (fin) begin
      n = seen_bytes;
      r = '0;
      if (n < IpMinHdr) begin
        r.verdict = STATUS_SHORT_IP;
      end else if (n < hdr_len) begin
        r.verdict = STATUS_SHORT_IHL;
      end else if (n - hdr_len < IcmpHdr) begin
        r.verdict = STATUS_SHORT_ICMP;
      end else begin
        ilen = n - hdr_len;
        plen_int = ilen - IcmpHdr;
        r.plen_val = plen_int[12:0];
        s = word_sum;
        if (ilen % 2 == 1) s = fold_add(s, {hi_byte, 8'h00});
        s = {1'b0, s[15:0]} + {16'd0, s[16]};
        calc = ~s[15:0];
        if (kind_field != 8'h00) begin
          r.verdict = STATUS_NOT_REPLY;
        end else if (calc != csum_field) begin
          r.verdict = STATUS_BAD_CSUM;
        end else begin
          r.ident_val = id_field;
          r.seq_val = seq_field;
          r.verdict = (plen_int != want_plen) ? STATUS_WRONG_SIZE : STATUS_OK;
        end
      end
      expected_verdicts.push_back(r);
      clear_frame_state();
    end
  endtask

  task automatic make_reply(input int ihl, input logic [7:0] kind, input int plen,
                            input bit bad_sum);
    int hl;
    int i;
    logic [3:0] hi_nib;
    logic [16:0] s;
    logic [15:0] csum;
    frame_bytes.delete();
    hl = ihl * 4;
    // With no IP header the type byte doubles as byte 0, so its low nibble must be zero.
    if (ihl == 0) kind = {kind[7:4] | kind[3:0], 4'h0};
    for (i = 0; i < hl; i++) begin
      if (i == 0) begin
        hi_nib = 4'($urandom_range(15));
        frame_bytes.push_back({hi_nib, ihl[3:0]});
      end else begin
        frame_bytes.push_back(rand_byte());
      end
    end
    frame_bytes.push_back(kind);
    for (i = 1; i < IcmpHdr + plen; i++)
      frame_bytes.push_back((i == 2 || i == 3) ? 8'h00 : rand_byte());
    s = '0;
    for (i = 0; i < IcmpHdr + plen; i += 2)
      s = fold_add(s, {frame_bytes[hl + i],
                       (i + 1 < IcmpHdr + plen) ? frame_bytes[hl + i + 1] : 8'h00});
    s = {1'b0, s[15:0]} + {16'd0, s[16]};
    csum = ~s[15:0];
    if (bad_sum) csum = csum ^ (16'd1 << $urandom_range(15));
    frame_bytes[hl + 2] = csum[15:8];
    frame_bytes[hl + 3] = csum[7:0];
  endtask

  task automatic make_noise(input int len);
    int i;
    frame_bytes.delete();
    for (i = 0; i < len; i++) frame_bytes.push_back(rand_byte());
  endtask

  task automatic queue_frame(input int len, input bit hold);
    int i;
    wire_byte_t w;
    for (i = 0; i < len; i++) begin
      w.value = frame_bytes[i];
      w.final_byte = (i == len - 1);
      w.hold = hold && (i == len - 1);
      tx_queue.push_back(w);
    end
  endtask

  task automatic run_random(input int budget);
    int sent;
    int pick;
    int ihl;
    int plen;
    int len;
    logic [7:0] kind;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      ihl = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
      plen = ($urandom_range(1) == 0 && gen_len <= 64) ? gen_len : $urandom_range(40);
      kind = 8'h00;
      if (pick < 12) kind = 8'($urandom_range(1, 255));
      if (pick < 85) begin
        make_reply(ihl, kind, plen, pick >= 12 && pick < 24);
        len = frame_bytes.size();
        if (pick >= 72) len = $urandom_range(1, len - 1);
      end else begin
        len = $urandom_range(1, 48);
        make_noise(len);
      end
      queue_frame(len, $urandom_range(19) == 0);
      sent += len;
    end
  endtask

  task automatic settle_idle();
    while (!(tx_queue.size() == 0 && !push && expected_verdicts.size() == 0))
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_expected_len(input logic [11:0] v);
    gen_len = v;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin : drive_bytes
    wire_byte_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || byte_taken) begin
      if (byte_taken && cur_hold) draining = 1'b1;
      if (draining && expected_verdicts.size() == 0) draining = 1'b0;
      if (!draining && tx_queue.size() != 0 &&
          (steady || $urandom_range(99) >= IdlePercent)) begin
        nxt = tx_queue.pop_front();
        cur_hold = nxt.hold;
        data_byte <= nxt.value;
        last <= nxt.final_byte;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= steady || $urandom_range(99) >= IdlePercent;
  end

  always @(posedge clk) begin : watch_outputs
    echo_verdict_t want;
    byte_taken = 1'b0;
    if (rst) begin
      clear_frame_state();
      want_plen = EXPECTED_LEN_RESET;
    end else begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (cfg_valid && cfg_ready) want_plen = cfg_data;
      if (push && !full) begin
        byte_taken = 1'b1;
        bytes_sent++;
        track_byte(data_byte, last);
      end
      if (pop && !empty) begin
        if (expected_verdicts.size() == 0) begin
          $error("verdict transfer with nothing expected: status %0d", status);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          verdicts_seen++;
          if (status !== want.verdict) begin
            $error("status: expected %0d, got %0d", want.verdict, status);
            errors++;
          end else if (status <= 3'd6) begin
            verdict_hits[status]++;
          end
          if (ident !== want.ident_val) begin
            $error("ident: expected %0h, got %0h", want.ident_val, ident);
            errors++;
          end
          if (sequence_res !== want.seq_val) begin
            $error("sequence_res: expected %0h, got %0h", want.seq_val, sequence_res);
            errors++;
          end
          if (payload_len !== want.plen_val) begin
            $error("payload_len: expected %0d, got %0d", want.plen_val, payload_len);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("Timeout: no transfer for %0d cycles.", QuietLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    make_noise(1);
    frame_bytes[0] = 8'hFF;
    queue_frame(1, 1'b0);
    make_noise(1);
    frame_bytes[0] = 8'h00;
    queue_frame(1, 1'b0);
    make_noise(19);
    queue_frame(19, 1'b0);
    make_reply(15, 8'h00, 56, 1'b0);
    queue_frame(40, 1'b0);
    make_reply(5, 8'h00, 56, 1'b0);
    queue_frame(25, 1'b0);
    make_reply(5, 8'h08, 56, 1'b0);
    queue_frame(frame_bytes.size(), 1'b0);
    make_reply(5, 8'h00, 56, 1'b1);
    queue_frame(frame_bytes.size(), 1'b0);
    make_reply(5, 8'h00, 56, 1'b0);
    queue_frame(frame_bytes.size(), 1'b1);
    make_reply(5, 8'h00, 0, 1'b0);
    queue_frame(frame_bytes.size(), 1'b0);
    make_reply(0, 8'h00, 56, 1'b0);
    queue_frame(frame_bytes.size(), 1'b0);
    make_reply(5, 8'h00, 57, 1'b0);
    queue_frame(frame_bytes.size(), 1'b0);
    make_reply(1, 8'h00, 3, 1'b0);
    queue_frame(frame_bytes.size(), 1'b0);
    make_reply(4, 8'h00, 0, 1'b0);
    queue_frame(frame_bytes.size(), 1'b0);
    settle_idle();
    run_random(520);

    settle_idle();
    set_expected_len(12'd0);
    steady = 1'b1;
    run_random(520);
    settle_idle();
    steady = 1'b0;

    // The final marker lands past MaxPacket bytes, so the tail bytes must be ignored.
    set_expected_len(12'd4068);
    make_reply(5, 8'h00, 4068, 1'b0);
    repeat (9) frame_bytes.push_back(rand_byte());
    queue_frame(frame_bytes.size(), 1'b0);
    run_random(100);

    settle_idle();
    set_expected_len(12'($urandom_range(1, 40)));
    run_random(520);
    settle_idle();

    $display("Checked %0d verdicts over %0d byte transfers at payload lengths 56, 0, 4068, %0d.",
             verdicts_seen, bytes_sent, gen_len);
    $display("Matching verdicts by status 0..6: %0d %0d %0d %0d %0d %0d %0d",
             verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
             verdict_hits[4], verdict_hits[5], verdict_hits[6]);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- icmp_echo_reply_checker_core.f -----
sv/iecr_pkg.sv
sv/iecr_front.sv
sv/iecr_fifo.sv
sv/iecr_back.sv
sv/icmp_echo_reply_checker_core.sv
tb/sv/icmp_echo_reply_checker_core_tb.sv
